@@ rtl/rsl256_pkg.sv @@
// Package for the base-256 LSD radix sorter.
// Holds the key and digit constants that the sorter's datapath and sequencer share.
package rsl256_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DIGIT_W  = 8;
  localparam int unsigned RADIX    = 256;
  localparam int unsigned PASS_W   = 2;
  localparam int unsigned RADIX_AW = 8;

  localparam logic [KEY_W-1:0]    SIGN_FLIP = 32'h8000_0000;
  localparam logic [PASS_W-1:0]   LAST_PASS = 2'd3;
  localparam logic [RADIX_AW:0]   SCAN_END  = 9'd256;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  // Select one 8-bit digit of a key, least significant digit for pass zero.
  function automatic digit_t digit_of(input key_t key, input logic [PASS_W-1:0] pass);
    digit_t d;
    unique case (pass)
      2'd0:    d = key[7:0];
      2'd1:    d = key[15:8];
      2'd2:    d = key[23:16];
      default: d = key[31:24];
    endcase
    return d;
  endfunction

endpackage

@@ rtl/rsl256_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
module rsl256_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/radix_sort_lsd_base256_top.sv @@
// Base-256 LSD radix sorter of signed 32-bit values, top level.
// Depends on rsl256_pkg and rsl256_ram (two key buffers and the digit count memory).
//
// Values are loaded one per cycle while busy is low; an item with last_i closes the set and
// raises busy until the sorted set has been sent. A set of n stored values (n <= MAX_ITEMS)
// goes through four digit passes after the closing item. Each pass counts every element
// (key read, count read, count write), scans the 256-entry count memory into exclusive
// offsets, and scatters every element (key read, count read, key and count write); these
// steps are set by the single read port of the key and count memories. A set of one value
// skips the passes. Results leave one per cycle on strobe_o and cannot be held off;
// overflow_o is high on every result of a set from which values beyond capacity were
// dropped. busy drops during the final result, and a new item may be taken in that same cycle.
module radix_sort_lsd_base256_top #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  output logic               strobe_o,
  output logic signed [31:0] sorted_value_o,
  output logic               last_res_o,
  output logic               overflow_o
);
  import rsl256_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT_KEY,
    S_CNT_CNT,
    S_CNT_WR,
    S_SCAN,
    S_SCT_KEY,
    S_SCT_CNT,
    S_SCT_WR,
    S_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                drop_q, drop_d;
  logic [CW-1:0]       n_q, n_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [PASS_W-1:0]   pass_q, pass_d;
  logic                bank_q, bank_d;
  logic [CW-1:0]       total_q, total_d;
  logic [RADIX_AW:0]   scan_q, scan_d;
  digit_t              dig_q, dig_d;
  key_t                key_q, key_d;
  logic                out_v_q, out_v_d;
  logic                out_last_q, out_last_d;
  logic                out_ovf_q, out_ovf_d;
  logic [RADIX-1:0]    cvalid_q;
  logic                rd_valid_q;
  logic                cvalid_clr;

  logic                accept;
  logic                full;

  logic                k0_we, k1_we;
  logic [IW-1:0]       k0_waddr, k1_waddr;
  key_t                k0_wdata, k1_wdata;
  logic                key_re;
  logic [IW-1:0]       key_raddr;
  key_t                k0_rdata, k1_rdata, key_rdata;

  logic                c_we, c_re;
  logic [RADIX_AW-1:0] c_waddr, c_raddr;
  logic [CW-1:0]       c_wdata, c_rdata, cnt_val;

  assign accept    = start && !busy;
  assign full      = (cnt_q == CAP);
  assign busy      = (state_q != S_IDLE);
  assign key_rdata = bank_q ? k1_rdata : k0_rdata;
  assign cnt_val   = rd_valid_q ? c_rdata : '0;

  rsl256_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_key0 (
    .clk_i   (clk_i),
    .we_i    (k0_we),
    .waddr_i (k0_waddr),
    .wdata_i (k0_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (k0_rdata)
  );

  rsl256_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_key1 (
    .clk_i   (clk_i),
    .we_i    (k1_we),
    .waddr_i (k1_waddr),
    .wdata_i (k1_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (k1_rdata)
  );

  rsl256_ram #(.WIDTH(CW), .DEPTH(RADIX)) u_count (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    n_d        = n_q;
    idx_d      = idx_q;
    pass_d     = pass_q;
    bank_d     = bank_q;
    total_d    = total_q;
    scan_d     = scan_q;
    dig_d      = dig_q;
    key_d      = key_q;
    out_v_d    = 1'b0;
    out_last_d = 1'b0;
    out_ovf_d  = out_ovf_q;
    cvalid_clr = 1'b0;

    k0_we    = 1'b0;
    k0_waddr = cnt_q[IW-1:0];
    k0_wdata = key_t'(value_i) ^ SIGN_FLIP;
    k1_we    = 1'b0;
    k1_waddr = cnt_val[IW-1:0];
    k1_wdata = key_q;
    key_re    = 1'b0;
    key_raddr = idx_q[IW-1:0];

    c_we    = 1'b0;
    c_waddr = dig_q;
    c_wdata = CW'(cnt_val + CW'(1));
    c_re    = 1'b0;
    c_raddr = digit_of(key_rdata, pass_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!full) begin
            k0_we = 1'b1;
            cnt_d = CW'(cnt_q + CW'(1));
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) begin
            n_d     = full ? cnt_q : CW'(cnt_q + CW'(1));
            idx_d   = '0;
            pass_d  = '0;
            bank_d  = 1'b0;
            total_d = '0;
            if (full || cnt_q != '0) begin
              cvalid_clr = 1'b1;
              state_d    = S_CNT_KEY;
            end else begin
              state_d = S_OUT;
            end
          end
        end
      end
      S_CNT_KEY, S_SCT_KEY: begin
        key_re  = 1'b1;
        state_d = (state_q == S_CNT_KEY) ? S_CNT_CNT : S_SCT_CNT;
      end
      S_CNT_CNT, S_SCT_CNT: begin
        c_re    = 1'b1;
        dig_d   = digit_of(key_rdata, pass_q);
        key_d   = key_rdata;
        state_d = (state_q == S_CNT_CNT) ? S_CNT_WR : S_SCT_WR;
      end
      S_CNT_WR: begin
        c_we  = 1'b1;
        idx_d = CW'(idx_q + CW'(1));
        if (idx_d == n_q) begin
          idx_d   = '0;
          scan_d  = '0;
          total_d = '0;
          state_d = S_SCAN;
        end else begin
          state_d = S_CNT_KEY;
        end
      end
      S_SCAN: begin
        // Read entry k while writing the exclusive offset of entry k-1.
        c_re    = (scan_q != SCAN_END);
        c_raddr = scan_q[RADIX_AW-1:0];
        if (scan_q != '0) begin
          c_we    = 1'b1;
          c_waddr = RADIX_AW'(scan_q - 9'd1);
          c_wdata = total_q;
          total_d = CW'(total_q + cnt_val);
        end
        scan_d = scan_q + 9'd1;
        if (scan_q == SCAN_END) begin
          state_d = S_SCT_KEY;
        end
      end
      S_SCT_WR: begin
        c_we  = 1'b1;
        k0_waddr = cnt_val[IW-1:0];
        k0_wdata = key_q;
        if (bank_q) begin
          k0_we = 1'b1;
        end else begin
          k1_we = 1'b1;
        end
        idx_d = CW'(idx_q + CW'(1));
        if (idx_d == n_q) begin
          idx_d  = '0;
          bank_d = !bank_q;
          pass_d = pass_q + PASS_W'(1);
          if (pass_q == LAST_PASS) begin
            state_d = S_OUT;
          end else begin
            cvalid_clr = 1'b1;
            state_d    = S_CNT_KEY;
          end
        end else begin
          state_d = S_SCT_KEY;
        end
      end
      S_OUT: begin
        key_re     = 1'b1;
        out_v_d    = 1'b1;
        out_ovf_d  = drop_q;
        idx_d      = CW'(idx_q + CW'(1));
        out_last_d = (idx_d == n_q);
        if (out_last_d) begin
          cnt_d   = '0;
          drop_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      drop_q     <= 1'b0;
      n_q        <= '0;
      idx_q      <= '0;
      pass_q     <= '0;
      bank_q     <= 1'b0;
      total_q    <= '0;
      scan_q     <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_ovf_q  <= 1'b0;
      cvalid_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      drop_q     <= drop_d;
      n_q        <= n_d;
      idx_q      <= idx_d;
      pass_q     <= pass_d;
      bank_q     <= bank_d;
      total_q    <= total_d;
      scan_q     <= scan_d;
      out_v_q    <= out_v_d;
      out_last_q <= out_last_d;
      out_ovf_q  <= out_ovf_d;
      if (c_re) begin
        rd_valid_q <= cvalid_q[c_raddr];
      end
      if (cvalid_clr) begin
        cvalid_q <= '0;
      end else if (c_we) begin
        cvalid_q[c_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    key_q <= key_d;
  end

  assign strobe_o       = out_v_q;
  assign sorted_value_o = $signed(key_rdata ^ SIGN_FLIP);
  assign last_res_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

  a_strobe_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(state_q == S_OUT))
    else $error("result strobe without an output read");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_res_o |=> !strobe_o)
    else $error("result after the final result of a set");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP)
    else $error("fill count beyond capacity");

  a_close_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_i |=> busy)
    else $error("closing request did not start the sort");

  a_index_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (idx_q < n_q) && (n_q != '0))
    else $error("element index outside the set");

endmodule

@@ sim/tb_radix_sort_lsd_base256_top.sv @@
`timescale 1ns / 100ps
// Testbench for radix_sort_lsd_base256_top: sends sets of signed values and predicts each sorted set.
// Checks every result strobe in order against the prediction.
// Depends on rsl256_pkg and the sorter RTL only.
module tb_radix_sort_lsd_base256_top;
  import rsl256_pkg::*;

  localparam int unsigned MAX_ITEMS   = 64;
  localparam int unsigned N_ITEMS     = 470;
  localparam int unsigned LIMIT       = 2_000_000;
  localparam int unsigned DRAIN       = 50;
  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned N_DIRECTED  = 17;

  localparam digit_t CORNER_DIGITS [5] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hff};

  localparam logic signed [31:0] DIRECTED_VALS [N_DIRECTED] = '{
    32'sh8000_0000,
    32'sh7fff_ffff,
    32'sh0000_0000, 32'shffff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001,
    32'shffff_fffe,
    32'sh0000_0005, 32'shffff_fffb, 32'sh0000_0005, 32'sh0000_0000, 32'shffff_fffb,
    32'sh0100_0000, 32'sh00ff_ffff, 32'sh0001_0000, 32'sh0000_00ff
  };
  localparam logic [N_DIRECTED-1:0] DIRECTED_LAST = 17'b1_0001_0000_1100_0011;

  typedef enum int unsigned {VAL_FULL, VAL_DIGITS, VAL_NEAR_ZERO} val_mode_e;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               overflow;
  } sorted_res_t;

  class sort_scoreboard;
    key_t        set_keys[$];
    logic        set_dropped;
    sorted_res_t expected_q[$];
    int unsigned mismatches;

    function new();
      set_dropped = 1'b0;
      mismatches  = 0;
    endfunction

    function void note_request(logic signed [31:0] value, logic last);
      key_t        key;
      int          pos;
      sorted_res_t res;
      key = key_t'(value) ^ SIGN_FLIP;
      if (set_keys.size() < MAX_ITEMS) begin
        pos = 0;
        while (pos < set_keys.size() && set_keys[pos] <= key) pos++;
        set_keys.insert(pos, key);
      end else begin
        set_dropped = 1'b1;
      end
      if (last) begin
        foreach (set_keys[i]) begin
          res.value    = signed'(set_keys[i] ^ SIGN_FLIP);
          res.last     = (i == set_keys.size() - 1);
          res.overflow = set_dropped;
          expected_q.insert(expected_q.size(), res);
        end
        set_keys.delete();
        set_dropped = 1'b0;
      end
    endfunction

    function void report(string what, logic signed [31:0] exp_v, logic signed [31:0] act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_result(logic signed [31:0] value, logic last, logic overflow);
      sorted_res_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result expected none actual value=%0d last=%0b overflow=%0b",
                   $time, value, last, overflow);
        return;
      end
      exp_res = expected_q.pop_front();
      if (value !== exp_res.value) report("sorted_value", exp_res.value, value);
      if (last !== exp_res.last) report("last_res", exp_res.last, last);
      if (overflow !== exp_res.overflow) report("overflow", exp_res.overflow, overflow);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  logic signed [31:0] value_i = '0;
  logic               last_i  = 1'b0;
  logic               busy;
  logic               strobe_o;
  logic signed [31:0] sorted_value_o;
  logic               last_res_o;
  logic               overflow_o;

  sort_scoreboard sb = new();
  int unsigned    items_sent = 0;
  int unsigned    cycles     = 0;

  radix_sort_lsd_base256_top #(
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .last_i        (last_i),
    .strobe_o      (strobe_o),
    .sorted_value_o(sorted_value_o),
    .last_res_o    (last_res_o),
    .overflow_o    (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** radix_sort_lsd_base256_top: FAILED **");
      $finish;
    end
  end

  // sample in the second half of the cycle, when all outputs are settled
  always @(negedge clk_i) begin
    if (rst_ni && strobe_o) sb.check_result(sorted_value_o, last_res_o, overflow_o);
  end

  function automatic logic signed [31:0] pick_value(val_mode_e mode);
    logic [31:0] v;
    case (mode)
      VAL_DIGITS: begin
        for (int b = 0; b < 4; b++)
          v[8*b +: 8] = ($urandom_range(0, 5) == 5) ? digit_t'($urandom)
                                                    : CORNER_DIGITS[$urandom_range(0, 4)];
      end
      VAL_NEAR_ZERO: v = $urandom_range(0, 15) - 8;
      default: v = $urandom;
    endcase
    return signed'(v);
  endfunction

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_request(logic signed [31:0] value, logic last, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= value;
    last_i  <= last;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    sb.note_request(value, last);
    items_sent++;
  endtask

  task automatic send_set(int unsigned len, val_mode_e mode, bit no_gaps);
    for (int unsigned k = 0; k < len; k++)
      send_request(pick_value(mode), k == len - 1, no_gaps ? 0 : $urandom_range(0, 15));
  endtask

  initial begin
    int unsigned set_idx;
    int unsigned len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      send_request(DIRECTED_VALS[i], DIRECTED_LAST[i], $urandom_range(0, 15));

    set_idx = 0;
    while (items_sent < N_ITEMS) begin
      case (set_idx % 12)
        5:       len = MAX_ITEMS;
        11:      len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
        default: len = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(2, 10);
      endcase
      send_set(len, val_mode_e'($urandom_range(0, 2)), $urandom_range(0, 3) == 0);
      set_idx++;
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("** radix_sort_lsd_base256_top: PASSED **");
    end else begin
      $display("** radix_sort_lsd_base256_top: FAILED **");
    end
    $finish;
  end

endmodule
